FILE: src/uart_commanded_position_servo_unit_assert.svh
// Assertion macros for the serial-commanded position servo.
`ifndef UART_COMMANDED_POSITION_SERVO_UNIT_ASSERT_SVH
`define UART_COMMANDED_POSITION_SERVO_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UCPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define UCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ucps_pkg.sv
// Shared types, codes and tables of the serial-commanded position servo.
`default_nettype none
package ucps_pkg;

  localparam logic [7:0]  START_BYTE  = 8'd255;
  localparam logic [7:0]  CMD_SPEED   = 8'd3;
  localparam logic [7:0]  CMD_TARGET  = 8'd4;
  localparam logic [7:0]  ESC_LO      = 8'd1;
  localparam logic [7:0]  ESC_HI      = 8'd2;
  localparam logic [7:0]  ESC_BOTH    = 8'd3;
  localparam logic [7:0]  FORCED_BYTE = 8'd255;

  localparam logic [6:0]  PERCENT_MAX = 7'd100;
  localparam logic [15:0] FULL_DUTY   = 16'd65535;

  localparam logic [6:0]  LIMIT_RESET  = 7'd50;
  localparam logic [15:0] TARGET_RESET = 16'd10;

  localparam logic [7:0]  GAIN_RESET   = 8'd7;
  localparam logic [15:0] PERIOD_RESET = 16'd15000;
  localparam logic [15:0] SCALE_RESET  = 16'd13457;
  localparam logic [15:0] DBAND_RESET  = 16'd32768;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;
  localparam logic [CFG_AW-1:0] REG_GAIN   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_PERIOD = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SCALE  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_DBAND  = 2'd3;

  localparam logic [1:0] DIR_OFF = 2'd0;
  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_REV = 2'd2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // reciprocal of the percent scale, exact for products below 2^30
  localparam longint unsigned PCT_RECIP = ((64'd1 << 32) / 64'(PERCENT_MAX)) + 64'd1;

  typedef logic [15:0] duty_tbl_t [128];

  function automatic duty_tbl_t build_duty();
    duty_tbl_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = 16'((64'(i) * 64'(FULL_DUTY) * PCT_RECIP) >> 32);
    end
    return t;
  endfunction

  localparam duty_tbl_t DUTY_TABLE = build_duty();

  typedef struct packed {
    logic mul;
    logic acc;
    logic err;
    logic mag;
    logic gain;
    logic drive;
    logic pwm;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

FILE: src/ucps_frame.sv
// Serial frame parser holding the speed limit and target position.
`default_nettype none
module ucps_frame
  import ucps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_vld,
  input  wire logic [7:0] rx_byte,
  output logic [6:0]      speed_limit,
  output logic [15:0]     target
);

  typedef enum logic [2:0] {FP_WAIT, FP_CMD, FP_HI, FP_LO, FP_ESC} fpos_t;

  fpos_t       state_r;
  logic [7:0]  cmd_r, hi_r, lo_r;
  logic [6:0]  limit_r;
  logic [15:0] tgt_r;
  logic [7:0]  hi_f, lo_f;
  logic [15:0] word;

  always_comb begin
    hi_f = hi_r;
    lo_f = lo_r;
    case (rx_byte)
      ESC_LO:   lo_f = FORCED_BYTE;
      ESC_HI:   hi_f = FORCED_BYTE;
      ESC_BOTH: begin
        lo_f = FORCED_BYTE;
        hi_f = FORCED_BYTE;
      end
      default: ;
    endcase
    word = {hi_f, lo_f};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FP_WAIT;
      cmd_r   <= '0;
      hi_r    <= '0;
      lo_r    <= '0;
      limit_r <= LIMIT_RESET;
      tgt_r   <= TARGET_RESET;
    end else if (byte_vld) begin
      if (state_r == FP_WAIT) begin
        if (rx_byte == START_BYTE) state_r <= FP_CMD;
      end else if (rx_byte == START_BYTE) begin
        state_r <= FP_WAIT;
      end else begin
        case (state_r)
          FP_CMD: begin
            cmd_r   <= rx_byte;
            state_r <= FP_HI;
          end
          FP_HI: begin
            hi_r    <= rx_byte;
            state_r <= FP_LO;
          end
          FP_LO: begin
            lo_r    <= rx_byte;
            state_r <= FP_ESC;
          end
          default: begin
            if (cmd_r == CMD_SPEED) begin
              limit_r <= (word > 16'(PERCENT_MAX)) ? PERCENT_MAX : word[6:0];
            end else if (cmd_r == CMD_TARGET) begin
              tgt_r <= word;
            end
            state_r <= FP_WAIT;
          end
        endcase
      end
    end
  end

  assign speed_limit = limit_r;
  assign target      = tgt_r;

endmodule
`default_nettype wire

FILE: src/ucps_ctrl.sv
// Tick sequencer stepping the datapath through one control update.
`default_nettype none
module ucps_ctrl
  import ucps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic in_kind,
  input  wire sts_t sts,
  output logic      in_tready,
  output cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_ERR, S_MAG, S_GAIN, S_DRIVE, S_PWM, S_DIV
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid && in_kind) state_nxt = S_ACC;
      S_ACC:   state_nxt = S_ERR;
      S_ERR:   state_nxt = S_MAG;
      S_MAG:   state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_DRIVE;
      S_DRIVE: state_nxt = S_PWM;
      S_PWM:   state_nxt = S_DIV;
      S_DIV:   if (!sts.out_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.mul   = (state_r == S_IDLE) && in_tvalid && in_tready_r && in_kind;
    cmd.acc   = (state_r == S_ACC);
    cmd.err   = (state_r == S_ERR);
    cmd.mag   = (state_r == S_MAG);
    cmd.gain  = (state_r == S_GAIN);
    cmd.drive = (state_r == S_DRIVE);
    cmd.pwm   = (state_r == S_PWM);
    cmd.load  = (state_r == S_DIV) && !sts.out_full;
  end

  assign in_tready = in_tready_r;

endmodule
`default_nettype wire

FILE: src/ucps_dp.sv
// Position accumulator, proportional drive and PWM compare datapath.
`default_nettype none
module ucps_dp
  import ucps_pkg::*;
#(
  parameter int F = 16,
  parameter int W = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic [15:0]           up_count,
  input  wire logic [15:0]           down_count,
  input  wire logic [6:0]            speed_limit,
  input  wire logic [15:0]           target,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_AW-1:0]     cfg_addr,
  input  wire logic [CFG_DW-1:0]     cfg_wdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int XW = 16 + F;
  localparam int PW = F + 18;
  localparam int EW = (PW > W) ? PW : W;
  localparam int DW = ((W > XW) ? W : XW) + 2;
  localparam int GW = F + 15;

  logic [7:0]  gain_r;
  logic [15:0] period_r, scale_r, dband_r;

  logic signed [PW-1:0] prod_r;
  logic [W-1:0]         pos_r;
  logic signed [DW-1:0] err_r;
  logic [DW-1:0]        mag_r;
  logic                 pos_dir_r;
  logic [GW-1:0]        gprod_r;
  logic                 big_r;
  logic [1:0]           dir_r;
  logic [6:0]           drive_r;
  logic [31:0]          pprod_r;
  logic                 duty_nz_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [XW-1:0]        scale_x, dband_x;
  logic [F-1:0]         step, dband;
  logic signed [16:0]   diff;
  logic signed [F:0]    step_s;
  logic signed [EW-1:0] prod_ext;
  logic [DW-1:0]        tgt_ext;
  logic signed [DW-1:0] pos_ext;
  logic [14:0]          raw;
  logic [15:0]          duty;
  logic [15:0]          q0, quot;
  logic [16:0]          rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      period_r <= PERIOD_RESET;
      scale_r  <= SCALE_RESET;
      dband_r  <= DBAND_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GAIN:   gain_r   <= cfg_wdata[7:0];
        REG_PERIOD: period_r <= cfg_wdata;
        REG_SCALE:  scale_r  <= cfg_wdata;
        REG_DBAND:  dband_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    scale_x  = XW'(scale_r) << F;
    dband_x  = XW'(dband_r) << F;
    step     = scale_x[XW-1:16];
    dband    = dband_x[XW-1:16];
    diff     = $signed({1'b0, up_count}) - $signed({1'b0, down_count});
    step_s   = $signed({1'b0, step});
    prod_ext = EW'(prod_r);
    tgt_ext  = DW'({target, {F{1'b0}}});
    pos_ext  = DW'($signed(pos_r));
    if (gain_r == 8'd0) begin
      raw = '0;
    end else if (big_r) begin
      raw = 15'd128;
    end else begin
      raw = gprod_r[GW-1:F];
    end
    duty = DUTY_TABLE[drive_r];
    q0   = pprod_r[31:16];
    rem  = {1'b0, pprod_r[15:0]} + {1'b0, q0};
    quot = q0 + 16'(rem >= {1'b0, FULL_DUTY});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.acc) begin
      pos_r <= pos_r + prod_ext[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= PW'(diff) * PW'(step_s);
    if (cmd.err) err_r <= $signed(tgt_ext) - pos_ext;
    if (cmd.mag) begin
      mag_r     <= err_r[DW-1] ? DW'(-err_r) : DW'(err_r);
      pos_dir_r <= ~err_r[DW-1];
    end
    if (cmd.gain) begin
      gprod_r <= GW'(mag_r[F+6:0]) * GW'(gain_r);
      big_r   <= (mag_r >> (F + 7)) != '0;
      if ((mag_r > DW'(dband)) && (mag_r != '0)) begin
        dir_r <= pos_dir_r ? DIR_FWD : DIR_REV;
      end else begin
        dir_r <= DIR_OFF;
      end
    end
    if (cmd.drive) drive_r <= (raw > 15'(speed_limit)) ? speed_limit : raw[6:0];
    if (cmd.pwm) begin
      pprod_r   <= 32'(period_r) * 32'(FULL_DUTY - duty);
      duty_nz_r <= (duty != 16'd0);
    end
    if (cmd.load) out_data_r <= OUT_DATA_W'({drive_r, dir_r, duty_nz_r, quot});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_full = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule
`default_nettype wire

FILE: src/uart_commanded_position_servo_unit.sv
// Top level of the serial-commanded proportional position servo.
// A serial byte is taken while the sequencer is idle. An accepted tick walks the accumulate,
// error, magnitude, gain, drive, PWM and divide states, then loads the output register once it
// is free and raises out_tvalid; no new tick is taken until idle. The output register lets the
// next item enter while a result waits to be taken. Synchronous active-low reset restores the
// register defaults, frame state, limit 50, target 10 and position zero.
`default_nettype none
module uart_commanded_position_servo_unit
  import ucps_pkg::*;
#(
  parameter int POSITION_FRACTION_BITS = 16,
  parameter int POSITION_WIDTH         = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // rx_byte, up_count, down_count
  input  wire logic                  in_tuser,   // kind
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // compare_value, timer_run, direction,
                                                 // drive_percent, zero fill
  input  wire logic                  cfg_we,
  input  wire logic [CFG_AW-1:0]     cfg_addr,
  input  wire logic [CFG_DW-1:0]     cfg_wdata
);

  cmd_t        cmd;
  sts_t        sts;
  logic [6:0]  speed_limit;
  logic [15:0] target;
  logic        byte_vld;

  assign byte_vld = in_tvalid && in_tready && !in_tuser;

  ucps_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_vld    (byte_vld),
    .rx_byte     (in_tdata[7:0]),
    .speed_limit (speed_limit),
    .target      (target)
  );

  ucps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  ucps_dp #(
    .F (POSITION_FRACTION_BITS),
    .W (POSITION_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .up_count    (in_tdata[23:8]),
    .down_count  (in_tdata[39:24]),
    .speed_limit (speed_limit),
    .target      (target),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire

FILE: src/ucps_chk.sv
// Port-level checks of the servo and their binding to the top level.
`default_nettype none
`include "uart_commanded_position_servo_unit_assert.svh"
module ucps_chk
  import ucps_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  `UCPS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `UCPS_ASSERT_NEXT(a_no_early, in_tvalid && in_tready && !out_tvalid, !out_tvalid, "result one cycle after accept")
  `UCPS_ASSERT_NOW(a_drive_max, out_tvalid, out_tdata[25:19] <= PERCENT_MAX, "drive above full scale")
  `UCPS_ASSERT_NOW(a_dir_code, out_tvalid, out_tdata[18:17] != 2'd3, "invalid direction code")
  `UCPS_ASSERT_NOW(a_run_drive, out_tvalid, out_tdata[16] == (out_tdata[25:19] != 7'd0), "run flag mismatch")

endmodule

bind uart_commanded_position_servo_unit ucps_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
